@@ src/sbts_pkg.sv @@
// ----------------------------------------------------------------------------
// sbts_pkg
// Shared types and constants of the staged bring-up / tear-down sequencer.
// ----------------------------------------------------------------------------
package sbts_pkg;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_WIND   = 2'd1;
    localparam logic [1:0] ACT_UNWIND = 2'd2;
    localparam logic [1:0] ACT_EVENT  = 2'd3;

    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_WIND   = 2'd1;
    localparam logic [1:0] DIR_UNWIND = 2'd2;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_WOUND   = 2'd1;
    localparam logic [1:0] ST_UNWOUND = 2'd2;

    localparam logic [2:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [2:0] REG_SKIP        = 3'd1;
    localparam logic [2:0] REG_RETRY       = 3'd2;
    localparam logic [2:0] REG_EVENT_MASK  = 3'd3;
    localparam logic [2:0] REG_SAFE        = 3'd4;

    localparam logic [4:0]  LVL_NONE   = 5'h1F;
    localparam logic [31:0] SKIP_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  stage_count;
        logic [63:0] skip_periods;
        logic [63:0] retry_limits;
        logic [7:0]  event_wait_mask;
        logic [23:0] safe_levels;
    } cfg_t;

    typedef struct packed {
        logic              accepted;
        logic signed [3:0] reply_level;
        logic              busy_res;
        logic signed [3:0] current_level;
        logic              call_wind;
        logic              call_unwind;
        logic [2:0]        call_stage;
        logic              init_request;
        logic              level_changed;
        logic              report_valid;
        logic [1:0]        report_state;
    } result_t;

    // stages 8 and up read every field as zero
    function automatic logic [7:0] field8(input logic [63:0] r, input logic [3:0] idx);
        logic [7:0] f;
        f = idx[3] ? 8'd0 : r[{idx[2:0], 3'b000} +: 8];
        return f;
    endfunction

    function automatic logic ev_wait(input logic [7:0] m, input logic [3:0] idx);
        logic b;
        b = idx[3] ? 1'b0 : m[idx[2:0]];
        return b;
    endfunction

    function automatic logic [2:0] safe_of(input logic [23:0] r, input logic [3:0] idx);
        logic [2:0] f;
        f = idx[3] ? 3'd0 : r[idx[2:0] * 3 +: 3];
        return f;
    endfunction

endpackage

@@ src/staged_bringup_teardown_sequencer.sv @@
// ----------------------------------------------------------------------------
// staged_bringup_teardown_sequencer
// A request's result is registered: it sits in the output register from the cycle after acceptance.
// Throughput: one request per cycle while in_ready is high; the next-state logic is a single pass.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, async): no stage selected, no direction, retry counters cleared,
// skip counter set to all ones, configuration back to one stage with all tables zero.
// ----------------------------------------------------------------------------
module staged_bringup_teardown_sequencer #(
    parameter int STAGES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic              stage_ok,
    input  logic [2:0]        event_level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              accepted,
    output logic signed [3:0] reply_level,
    output logic              busy_res,
    output logic signed [3:0] current_level,
    output logic              call_wind,
    output logic              call_unwind,
    output logic [2:0]        call_stage,
    output logic              init_request,
    output logic              level_changed,
    output logic              report_valid,
    output logic [1:0]        report_state
);

    sbts_pkg::cfg_t    cfg_reg;
    sbts_pkg::result_t res_comb;
    sbts_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              take;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stage_count     <= 4'd1;
            cfg_reg.skip_periods    <= '0;
            cfg_reg.retry_limits    <= '0;
            cfg_reg.event_wait_mask <= '0;
            cfg_reg.safe_levels     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                sbts_pkg::REG_STAGE_COUNT: cfg_reg.stage_count     <= pwdata[3:0];
                sbts_pkg::REG_SKIP:        cfg_reg.skip_periods    <= pwdata;
                sbts_pkg::REG_RETRY:       cfg_reg.retry_limits    <= pwdata;
                sbts_pkg::REG_EVENT_MASK:  cfg_reg.event_wait_mask <= pwdata[7:0];
                sbts_pkg::REG_SAFE:        cfg_reg.safe_levels     <= pwdata[23:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            sbts_pkg::REG_STAGE_COUNT: prdata = 64'(cfg_reg.stage_count);
            sbts_pkg::REG_SKIP:        prdata = cfg_reg.skip_periods;
            sbts_pkg::REG_RETRY:       prdata = cfg_reg.retry_limits;
            sbts_pkg::REG_EVENT_MASK:  prdata = 64'(cfg_reg.event_wait_mask);
            sbts_pkg::REG_SAFE:        prdata = 64'(cfg_reg.safe_levels);
            default:                   prdata = '0;
        endcase
    end

    sbts_core #(
        .STAGES (STAGES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .action      (action),
        .stage_ok    (stage_ok),
        .event_level (event_level),
        .cfg         (cfg_reg),
        .res         (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = res_reg.accepted;
    assign reply_level   = res_reg.reply_level;
    assign busy_res      = res_reg.busy_res;
    assign current_level = res_reg.current_level;
    assign call_wind     = res_reg.call_wind;
    assign call_unwind   = res_reg.call_unwind;
    assign call_stage    = res_reg.call_stage;
    assign init_request  = res_reg.init_request;
    assign level_changed = res_reg.level_changed;
    assign report_valid  = res_reg.report_valid;
    assign report_state  = res_reg.report_state;

endmodule

@@ src/sbts_core.sv @@
// ----------------------------------------------------------------------------
// sbts_core
// Sequencer state and its next-state logic; one request per take pulse.
// ----------------------------------------------------------------------------
module sbts_core #(
    parameter int STAGES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [1:0]          action,
    input  logic                stage_ok,
    input  logic [2:0]          event_level,
    input  sbts_pkg::cfg_t      cfg,
    output sbts_pkg::result_t   res
);

    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic [1:0]          dir_reg, dir_next;
    logic                wind_pend_reg, wind_pend_next;
    logic                unwind_pend_reg, unwind_pend_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [SW-1:0]       cur_stage_reg, cur_stage_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [SW-1:0]       prev_stage_reg, prev_stage_next;
    logic [4:0]          lvl_reg, lvl_next;
    logic [4:0]          lvl_rep_reg, lvl_rep_next;
    logic [31:0]         skip_reg, skip_next;
    logic [8:0]          retry_reg [STAGES];
    logic [8:0]          retry_next [STAGES];
    logic [STAGES-1:0]   up_done_reg, up_done_next;
    logic [STAGES-1:0]   ev_done_reg, ev_done_next;
    logic                failed_reg, failed_next;

    logic [4:0]          eff_count;

    always_comb
    begin
        if (cfg.stage_count == 4'd0)
        begin
            eff_count = 5'd1;
        end
        else if (5'(cfg.stage_count) > 5'(STAGES))
        begin
            eff_count = 5'(STAGES);
        end
        else
        begin
            eff_count = 5'(cfg.stage_count);
        end
    end

    always_comb
    begin
        logic [SW-1:0] s;
        logic [3:0]    s4;
        logic [8:0]    old;
        logic [1:0]    wu;
        logic          chk;
        logic          fail_exit;

        dir_next         = dir_reg;
        wind_pend_next   = wind_pend_reg;
        unwind_pend_next = unwind_pend_reg;
        cur_valid_next   = cur_valid_reg;
        cur_stage_next   = cur_stage_reg;
        prev_valid_next  = prev_valid_reg;
        prev_stage_next  = prev_stage_reg;
        lvl_next         = lvl_reg;
        lvl_rep_next     = lvl_rep_reg;
        skip_next        = skip_reg;
        retry_next       = retry_reg;
        up_done_next     = up_done_reg;
        ev_done_next     = ev_done_reg;
        failed_next      = failed_reg;
        res              = '0;
        res.reply_level  = -4'sd1;
        s                = '0;
        s4               = '0;
        old              = '0;
        wu               = sbts_pkg::ST_BUSY;
        chk              = 1'b0;
        fail_exit        = 1'b0;

        unique case (action)
            sbts_pkg::ACT_WIND:
            begin
                if (cur_valid_reg)
                begin
                    res.reply_level = 4'(cur_stage_reg);
                end
                else
                begin
                    wind_pend_next = 1'b1;
                    res.accepted   = 1'b1;
                end
            end
            sbts_pkg::ACT_UNWIND:
            begin
                unwind_pend_next = 1'b1;
                res.report_valid = 1'b1;
                if (cur_valid_reg)
                begin
                    ev_done_next[cur_stage_reg] = 1'b0;
                    res.reply_level  = 4'(cur_stage_reg);
                    res.report_state = sbts_pkg::ST_BUSY;
                end
                else
                begin
                    res.report_state = sbts_pkg::ST_UNWOUND;
                end
            end
            sbts_pkg::ACT_EVENT:
            begin
                if (cur_valid_reg && 4'(cur_stage_reg) == 4'(event_level))
                begin
                    ev_done_next[cur_stage_reg] = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                if (wind_pend_reg && dir_reg != sbts_pkg::DIR_WIND)
                begin
                    if (!cur_valid_next && !prev_valid_next)
                    begin
                        res.init_request = 1'b1;
                        for (int i = 0; i < STAGES; i++)
                        begin
                            retry_next[i] = '0;
                        end
                        up_done_next    = '0;
                        ev_done_next    = '0;
                        prev_valid_next = 1'b1;
                        prev_stage_next = '0;
                        lvl_next        = sbts_pkg::LVL_NONE;
                    end
                    cur_valid_next = prev_valid_next;
                    cur_stage_next = prev_stage_next;
                    dir_next       = sbts_pkg::DIR_WIND;
                end
                wind_pend_next = 1'b0;

                if (unwind_pend_reg && lvl_next != sbts_pkg::LVL_NONE)
                begin
                    if (!cur_valid_next || !up_done_next[cur_stage_next])
                    begin
                        cur_valid_next = prev_valid_next;
                        cur_stage_next = prev_stage_next;
                    end
                    dir_next = sbts_pkg::DIR_UNWIND;
                end
                unwind_pend_next = 1'b0;

                if (cur_valid_next)
                begin
                    s        = cur_stage_next;
                    s4       = 4'(s);
                    lvl_next = 5'(s);
                    if (dir_next == sbts_pkg::DIR_WIND)
                    begin
                        if (sbts_pkg::ev_wait(cfg.event_wait_mask, s4) && up_done_next[s])
                        begin
                            if (ev_done_next[s])
                            begin
                                if (5'(s) + 5'd1 < eff_count)
                                begin
                                    cur_stage_next = s + 1'b1;
                                end
                                else
                                begin
                                    cur_valid_next = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            if (skip_next >= 32'(sbts_pkg::field8(cfg.skip_periods, s4)))
                            begin
                                res.call_wind  = 1'b1;
                                res.call_stage = s4[2:0];
                                if (!stage_ok)
                                begin
                                    fail_exit     = 1'b1;
                                    old           = retry_next[s];
                                    retry_next[s] = old + 9'd1;
                                    if (old >= 9'(sbts_pkg::field8(cfg.retry_limits, s4)))
                                    begin
                                        skip_next       = sbts_pkg::SKIP_RESET;
                                        retry_next[s]   = '0;
                                        dir_next        = sbts_pkg::DIR_UNWIND;
                                        failed_next     = 1'b1;
                                        prev_valid_next = 1'b1;
                                        prev_stage_next = s;
                                        if (s != '0)
                                        begin
                                            cur_stage_next = s - 1'b1;
                                        end
                                        else
                                        begin
                                            cur_valid_next = 1'b0;
                                        end
                                    end
                                    else
                                    begin
                                        skip_next = '0;
                                    end
                                end
                                else
                                begin
                                    skip_next       = sbts_pkg::SKIP_RESET;
                                    up_done_next[s] = 1'b1;
                                end
                            end
                            else
                            begin
                                skip_next = skip_next + 32'd1;
                            end
                            if (!fail_exit)
                            begin
                                if (!sbts_pkg::ev_wait(cfg.event_wait_mask, s4))
                                begin
                                    prev_valid_next = 1'b1;
                                    prev_stage_next = s;
                                    up_done_next[s] = 1'b0;
                                    if (5'(s) + 5'd1 < eff_count)
                                    begin
                                        cur_stage_next = s + 1'b1;
                                    end
                                    else
                                    begin
                                        cur_valid_next = 1'b0;
                                        wu             = sbts_pkg::ST_WOUND;
                                    end
                                end
                                chk = 1'b1;
                            end
                        end
                    end
                    else if (dir_next == sbts_pkg::DIR_UNWIND)
                    begin
                        if (4'(sbts_pkg::safe_of(cfg.safe_levels, s4)) <= s4 && failed_next)
                        begin
                            failed_next = 1'b0;
                            dir_next    = sbts_pkg::DIR_WIND;
                        end
                        else
                        begin
                            res.call_unwind = 1'b1;
                            res.call_stage  = s4[2:0];
                            if (!stage_ok)
                            begin
                                old           = retry_next[s];
                                retry_next[s] = old + 9'd1;
                                if (old >= 9'(sbts_pkg::field8(cfg.retry_limits, s4)))
                                begin
                                    retry_next[s] = '0;
                                    dir_next      = sbts_pkg::DIR_WIND;
                                    failed_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                prev_valid_next = 1'b1;
                                prev_stage_next = s;
                                retry_next[s]   = '0;
                                up_done_next[s] = 1'b0;
                                ev_done_next[s] = 1'b0;
                                if (s != '0)
                                begin
                                    cur_stage_next = s - 1'b1;
                                end
                                else
                                begin
                                    cur_valid_next  = 1'b0;
                                    prev_valid_next = 1'b0;
                                    prev_stage_next = '0;
                                    wu              = sbts_pkg::ST_UNWOUND;
                                    lvl_next        = sbts_pkg::LVL_NONE;
                                end
                                chk = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        chk = 1'b1;
                    end
                end

                if (chk && lvl_rep_reg != lvl_next)
                begin
                    lvl_rep_next       = lvl_next;
                    res.level_changed  = 1'b1;
                    res.report_valid   = 1'b1;
                    res.report_state   = wu;
                end
            end
        endcase

        res.busy_res      = cur_valid_next;
        res.current_level = lvl_next[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg         <= sbts_pkg::DIR_NONE;
            wind_pend_reg   <= 1'b0;
            unwind_pend_reg <= 1'b0;
            cur_valid_reg   <= 1'b0;
            cur_stage_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            prev_stage_reg  <= '0;
            lvl_reg         <= '0;
            lvl_rep_reg     <= sbts_pkg::LVL_NONE;
            skip_reg        <= sbts_pkg::SKIP_RESET;
            for (int i = 0; i < STAGES; i++)
            begin
                retry_reg[i] <= '0;
            end
            up_done_reg     <= '0;
            ev_done_reg     <= '0;
            failed_reg      <= 1'b0;
        end
        else if (take)
        begin
            dir_reg         <= dir_next;
            wind_pend_reg   <= wind_pend_next;
            unwind_pend_reg <= unwind_pend_next;
            cur_valid_reg   <= cur_valid_next;
            cur_stage_reg   <= cur_stage_next;
            prev_valid_reg  <= prev_valid_next;
            prev_stage_reg  <= prev_stage_next;
            lvl_reg         <= lvl_next;
            lvl_rep_reg     <= lvl_rep_next;
            skip_reg        <= skip_next;
            retry_reg       <= retry_next;
            up_done_reg     <= up_done_next;
            ev_done_reg     <= ev_done_next;
            failed_reg      <= failed_next;
        end
    end

endmodule
